@@ src/hsvrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared types, widths and constants for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int CMAX         = (1 << CHANNEL_BITS) - 1;
   localparam int HUE_BITS     = 17;
   localparam int FRAC_BITS    = 16;
   localparam int SECTOR_BITS  = 3;
   localparam int K_BITS       = FRAC_BITS + 1;
   localparam int PROD_BITS    = 2 * CHANNEL_BITS;
   localparam int N_BITS       = PROD_BITS + FRAC_BITS;
   localparam int X_BITS       = N_BITS + 1;
   localparam int A_BITS       = X_BITS - FRAC_BITS;
   localparam int Q_BITS       = CHANNEL_BITS + 1;
   localparam int RECIP        = (1 << FRAC_BITS) / CMAX;
   localparam int RECIP_BITS   = FRAC_BITS - CHANNEL_BITS + 2;
   localparam int RP_BITS      = A_BITS + RECIP_BITS;

   localparam logic [K_BITS-1:0] K_ONE    = K_BITS'(1 << FRAC_BITS);
   localparam logic [X_BITS-1:0] ROUND_UP = X_BITS'((CMAX << FRAC_BITS) - 1);

   localparam logic [SECTOR_BITS-1:0] SECTOR_1 = 3'd1;
   localparam logic [SECTOR_BITS-1:0] SECTOR_2 = 3'd2;
   localparam logic [SECTOR_BITS-1:0] SECTOR_3 = 3'd3;
   localparam logic [SECTOR_BITS-1:0] SECTOR_4 = 3'd4;
   localparam logic [SECTOR_BITS-1:0] SECTOR_5 = 3'd5;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] saturation;
      logic [CHANNEL_BITS-1:0] brightness;
   } hsvrgb_req_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } hsvrgb_rsp_type;

endpackage

@@ src/hsvrgb_term.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB term pipeline
// Four stages computing ceil(prod * k / (CMAX * 2^16)) for one channel term.
// ----------------------------------------------------------------------------
module hsvrgb_term (
   input  logic                            clock,
   input  logic [3:0]                      stage_en,
   input  logic [hsvrgb_pkg::PROD_BITS-1:0] prod,
   input  logic [hsvrgb_pkg::K_BITS-1:0]    k,
   output logic [hsvrgb_pkg::Q_BITS-1:0]    ceil_q
);
   import hsvrgb_pkg::*;

   logic [N_BITS-1:0]  n_ff, n_in;
   logic [X_BITS-1:0]  x_sum;
   logic [A_BITS-1:0]  a_ff, a_in, a4_ff;
   logic [RP_BITS-1:0] recip_prod;
   logic [Q_BITS-1:0]  q0_ff, q0_in, q_ff, q_in;
   logic [A_BITS-1:0]  rem;

   // stage 2: full product
   assign n_in = N_BITS'(prod) * N_BITS'(k);

   // stage 3: add divisor minus one for the ceiling, drop the fraction scale
   assign x_sum = X_BITS'(n_ff) + ROUND_UP;
   assign a_in  = x_sum[FRAC_BITS +: A_BITS];

   // stage 4: estimate of a / CMAX, low by at most one
   assign recip_prod = RP_BITS'(a_ff) * RP_BITS'(RECIP);
   assign q0_in      = recip_prod[FRAC_BITS +: Q_BITS];

   // stage 5: correct the estimate
   assign rem  = a4_ff - A_BITS'(q0_ff) * A_BITS'(CMAX);
   assign q_in = q0_ff + Q_BITS'(rem >= A_BITS'(CMAX));

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         n_ff <= n_in;
      end
      if (stage_en[1]) begin
         a_ff <= a_in;
      end
      if (stage_en[2]) begin
         q0_ff <= q0_in;
         a4_ff <= a_ff;
      end
      if (stage_en[3]) begin
         q_ff <= q_in;
      end
   end

   assign ceil_q = q_ff;

endmodule

@@ src/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Six-stage pipeline turning saturation and brightness into RGB for a hue
// held in a control register.
// ----------------------------------------------------------------------------
// Usage:
//   csr_we / csr_wdata write the hue register (17 bits, 65536 = one full
//   turn, which wraps to hue 0). Write it only while the pipeline is empty.
//   req_valid / req_ready / req_data carry one item each: saturation and
//   brightness as 8-bit fractions of 255.
//   rsp_valid / rsp_ready / rsp_data carry one RGB item per request item,
//   in order.
// Throughput: one item per cycle unless stalled; every stage moves whenever
//   its successor has room, so bubbles are squeezed out while the output is stalled.
// Stages, in order: s*v product, three term products, ceiling offset,
//   reciprocal estimate, correction, select; rsp_valid follows the last.
// Reset: clears the hue to 0 and empties the pipeline; rsp_valid drops.
// Stall: a low rsp_ready holds the output item; earlier stages keep filling
//   until full, then req_ready drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [hsvrgb_pkg::HUE_BITS-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  hsvrgb_pkg::hsvrgb_req_type        req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output hsvrgb_pkg::hsvrgb_rsp_type        rsp_data
);
   import hsvrgb_pkg::*;

   localparam int STAGES = 6;

   logic [HUE_BITS-1:0]      hue_ff;
   logic [STAGES-1:0]        vld_ff, vld_in;
   logic [STAGES-1:0]        en;

   // hue decode: sector = floor(hue * 6), fraction f in the low bits
   logic [FRAC_BITS+2:0]     h6;
   logic [SECTOR_BITS-1:0]   sector;
   logic [K_BITS-1:0]        kq, kt;

   // stage 1 registers
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic [K_BITS-1:0]        kq_ff, kt_ff;

   // brightness and sector travel alongside the terms through stages 1 to 5
   logic [CHANNEL_BITS-1:0]  v_ff [5];
   logic [SECTOR_BITS-1:0]   sec_ff [5];

   logic [Q_BITS-1:0]        qp, qq, qt;
   logic [Q_BITS-1:0]        dp, dq, dt;
   logic [CHANNEL_BITS-1:0]  pv, qv, tv, vv;
   hsvrgb_rsp_type           rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff <= '0;
      end else if (csr_we) begin
         hue_ff <= csr_wdata;
      end
   end

   assign h6     = (FRAC_BITS + 3)'(hue_ff[FRAC_BITS-1:0]) * (FRAC_BITS + 3)'(6);
   assign sector = h6[FRAC_BITS +: SECTOR_BITS];
   assign kq     = K_BITS'(h6[FRAC_BITS-1:0]);
   assign kt     = K_ONE - kq;

   // stage enables: a stage advances when empty or when the next one advances
   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[0];

   always_comb begin
      vld_in = vld_ff;
      if (en[0]) begin
         vld_in[0] = req_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
         if (en[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: s * v, latch the hue-derived weights
   assign prod_in = PROD_BITS'(req_data.saturation) * PROD_BITS'(req_data.brightness);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff   <= prod_in;
         kq_ff     <= kq;
         kt_ff     <= kt;
         v_ff[0]   <= req_data.brightness;
         sec_ff[0] <= sector;
      end
      for (int i = 1; i < 5; i++) begin
         if (en[i]) begin
            v_ff[i]   <= v_ff[i-1];
            sec_ff[i] <= sec_ff[i-1];
         end
      end
   end

   // stages 2 to 5: ceiling of v*s*k / (255 * 2^16) for each term
   hsvrgb_term u_term_p (
      .clock    (clock),
      .stage_en (en[4:1]),
      .prod     (prod_ff),
      .k        (K_ONE),
      .ceil_q   (qp)
   );

   hsvrgb_term u_term_q (
      .clock    (clock),
      .stage_en (en[4:1]),
      .prod     (prod_ff),
      .k        (kq_ff),
      .ceil_q   (qq)
   );

   hsvrgb_term u_term_t (
      .clock    (clock),
      .stage_en (en[4:1]),
      .prod     (prod_ff),
      .k        (kt_ff),
      .ceil_q   (qt)
   );

   // stage 6: floor(v - x) = v - ceil(x); the ceiling never exceeds v
   assign dp = Q_BITS'(v_ff[4]) - qp;
   assign dq = Q_BITS'(v_ff[4]) - qq;
   assign dt = Q_BITS'(v_ff[4]) - qt;
   assign pv = dp[CHANNEL_BITS-1:0];
   assign qv = dq[CHANNEL_BITS-1:0];
   assign tv = dt[CHANNEL_BITS-1:0];
   assign vv = v_ff[4];

   // route the terms by sector; sector 0 takes the default arm
   always_comb begin
      case (sec_ff[4])
         SECTOR_1: begin
            rsp_in = '{red: qv, green: vv, blue: pv};
         end
         SECTOR_2: begin
            rsp_in = '{red: pv, green: vv, blue: tv};
         end
         SECTOR_3: begin
            rsp_in = '{red: pv, green: qv, blue: vv};
         end
         SECTOR_4: begin
            rsp_in = '{red: tv, green: pv, blue: vv};
         end
         SECTOR_5: begin
            rsp_in = '{red: vv, green: pv, blue: qv};
         end
         default: begin
            rsp_in = '{red: vv, green: tv, blue: pv};
         end
      endcase
   end

   // hold the output item until it is taken
   always_ff @(posedge clock) begin
      if (en[STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[STAGES-1];
   assign rsp_data  = rsp_ff;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives saturation/brightness items through the converter under a range of
// hue settings, predicts each RGB item with exact integer arithmetic and
// compares it field by field, with random idling on both channels and one
// long output stall that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module tb;
   import hsvrgb_pkg::*;

   localparam int HALF_PERIOD = 2;
   localparam int RESET_CYCLES = 6;
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake or register write
   localparam int DRAIN_CYCLES = 12;       // pipeline is six deep; allow twice
   localparam int LONG_HOLD_CYCLES = 200;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [HUE_BITS-1:0]    csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   hsvrgb_req_type         req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   hsvrgb_rsp_type         rsp_data;

   // Hue as the converter holds it, updated after each register write
   logic [HUE_BITS-1:0]    hue_shadow;
   // RGB items predicted for accepted inputs, oldest first
   hsvrgb_rsp_type         pending_rgb[$];

   int                     mismatches;
   int                     idle_cycles;
   int                     tx_gap_max;
   int                     rx_stall_max;
   int                     rx_hold_request;

   hsv_to_rgb_converter dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // floor(v * (CMAX*2^16 - s*k) / (CMAX*2^16)), truncated to one channel
   function automatic logic [CHANNEL_BITS-1:0] shade_term(
      input logic [CHANNEL_BITS-1:0] v,
      input logic [CHANNEL_BITS-1:0] s,
      input logic [K_BITS-1:0]       k
   );
      logic [63:0] scale;
      logic [63:0] product;
      scale   = 64'(CMAX) << FRAC_BITS;
      product = 64'(v) * (scale - 64'(s) * 64'(k));
      return CHANNEL_BITS'(product / scale);
   endfunction

   function automatic hsvrgb_rsp_type hsv_pixel(
      input logic [HUE_BITS-1:0]     h,
      input logic [CHANNEL_BITS-1:0] s,
      input logic [CHANNEL_BITS-1:0] v
   );
      logic [FRAC_BITS+2:0]    h6;
      logic [SECTOR_BITS-1:0]  sector;
      logic [K_BITS-1:0]       frac;
      logic [CHANNEL_BITS-1:0] p, q, t;
      hsvrgb_rsp_type          px;
      // only the low 16 bits count, so a full turn lands back on sector 0
      h6     = (FRAC_BITS+3)'(h[FRAC_BITS-1:0]) * (FRAC_BITS+3)'(6);
      sector = h6[FRAC_BITS+2:FRAC_BITS];
      frac   = K_BITS'(h6[FRAC_BITS-1:0]);
      p      = shade_term(v, s, K_ONE);
      q      = shade_term(v, s, frac);
      t      = shade_term(v, s, K_ONE - frac);
      case (sector)
         SECTOR_1: px = '{red: q, green: v, blue: p};
         SECTOR_2: px = '{red: p, green: v, blue: t};
         SECTOR_3: px = '{red: p, green: q, blue: v};
         SECTOR_4: px = '{red: t, green: p, blue: v};
         SECTOR_5: px = '{red: v, green: p, blue: q};
         default:  px = '{red: v, green: t, blue: p};
      endcase
      return px;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------

   // Offer one item after a random gap; return once it has been accepted.
   // Valid is left high so a back-to-back item needs no drop in between.
   task automatic send_pixel(input logic [CHANNEL_BITS-1:0] sat,
                             input logic [CHANNEL_BITS-1:0] bright);
      int gap;
      gap = $urandom_range(0, tx_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.saturation = sat;
      req_data.brightness = bright;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rgb.push_back(hsv_pixel(hue_shadow, sat, bright));
   endtask

   task automatic drop_req();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Write the hue only with the pipeline empty
   task automatic set_hue(input logic [HUE_BITS-1:0] h);
      drop_req();
      while (pending_rgb.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_wdata = h;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we     = 1'b0;
      hue_shadow = h;
   endtask

   // Lean towards the channel extremes, where truncation bites hardest
   function automatic logic [CHANNEL_BITS-1:0] pick_channel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return CHANNEL_BITS'(CMAX);
         default: return CHANNEL_BITS'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Receiver side: a random stall per item, and a long hold on request
   // ------------------------------------------------------------------------
   initial begin
      int stall;
      int hold;
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         if (rx_hold_request > 0) begin
            hold = rx_hold_request;
            rx_hold_request = 0;
            rsp_ready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         stall = $urandom_range(0, rx_stall_max);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Result checking: every accepted item against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      hsvrgb_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rgb.size() == 0) begin
            $error("unexpected item: red %0d green %0d blue %0d",
                   rsp_data.red, rsp_data.green, rsp_data.blue);
            mismatches++;
         end else begin
            want = pending_rgb.pop_front();
            if (rsp_data.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_data.red);
               mismatches++;
            end
            if (rsp_data.green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_data.green);
               mismatches++;
            end
            if (rsp_data.blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_data.blue);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: any handshake or register write counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Channel extremes at hue 0; every input bit goes both ways
   task automatic test_channel_corners();
      set_hue('0);
      send_pixel(8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF);
      send_pixel(8'hFF, 8'h00);
      send_pixel(8'hFF, 8'hFF);
      send_pixel(8'hAA, 8'h55);
      send_pixel(8'h55, 8'hAA);
   endtask

   // One hue just inside each sector, the top of sector 5 and a full turn
   task automatic test_sectors();
      logic [HUE_BITS-1:0] hues[7];
      hues = '{17'd10923, 17'd21846, 17'd32768, 17'd43691, 17'd54614,
               17'd65535, 17'd65536};
      foreach (hues[i]) begin
         set_hue(hues[i]);
         send_pixel(8'hFF, 8'hFF);
         send_pixel(8'hC8, 8'hB4);
      end
   endtask

   // Hold the output off while items keep coming, so the input must stall
   task automatic test_output_backpressure();
      set_hue(17'($urandom_range(0, 65536)));
      tx_gap_max = 0;
      rx_hold_request = LONG_HOLD_CYCLES;
      repeat (40) send_pixel(pick_channel(), pick_channel());
      tx_gap_max = 10;
   endtask

   // Random pixels over a series of hue settings and idling patterns
   task automatic test_random_pixels();
      logic [HUE_BITS-1:0] h;
      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            1:       h = 17'd65536;
            5:       h = 17'd65535;
            8:       h = '0;
            default: h = 17'($urandom_range(0, 65536));
         endcase
         set_hue(h);
         // a stretch with no idling at all, and one with a slow receiver only
         tx_gap_max   = (phase == 3 || phase == 7) ? 0 : 10;
         rx_stall_max = (phase == 3) ? 0 : 10;
         repeat (100) send_pixel(pick_channel(), pick_channel());
      end
      tx_gap_max   = 10;
      rx_stall_max = 10;
   endtask

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_data        = '0;
      hue_shadow      = '0;
      mismatches      = 0;
      idle_cycles     = 0;
      tx_gap_max      = 10;
      rx_stall_max    = 10;
      rx_hold_request = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_channel_corners();
      test_sectors();
      test_output_backpressure();
      test_random_pixels();

      // drain, then give the pipeline time to show any stray item
      drop_req();
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
